// ===== rtl/core/sqtu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SARSA Q-table update: shared types and constants
// Item and result payloads, register indexes, item commands and the
// controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package sqtu_pkg;

	// item commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_LEARN_RATE   = 2'd0;
	localparam logic [1:0] REG_DISCOUNT     = 2'd1;
	localparam logic [1:0] REG_EXPLORE_RATE = 2'd2;

	// register reset values, unsigned Q0.16
	localparam logic [15:0] LEARN_RATE_RST   = 16'd13107;
	localparam logic [15:0] DISCOUNT_RST     = 16'd58982;
	localparam logic [15:0] EXPLORE_RATE_RST = 16'd19661;

	typedef struct packed {
		logic               cmd;
		logic [3:0]         cur_x;
		logic [2:0]         cur_y;
		logic [1:0]         act;
		logic signed [7:0]  reward;
		logic [3:0]         next_x;
		logic [2:0]         next_y;
		logic [15:0]        explore_draw;
		logic [1:0]         random_action;
		logic signed [15:0] load_value;
	} item_t;

	typedef struct packed {
		logic [1:0]         next_action;
		logic signed [15:0] new_q;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic scan;
		logic mul1;
		logic td;
		logic mul2;
		logic wb;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} stat_t;

endpackage

// ===== rtl/core/sarsa_q_table_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SARSA Q-table update engine
// Step: the single read port scans the next cell then the current entry,
// then come two multiply stages with the TD sum between and write-back;
// a new item is accepted when busy drops. Load: goes straight to write-back,
// then the strobe is registered. Result shows for one cycle on done.
// Reset clears control and loads register defaults; the table is not cleared.
// ----------------------------------------------------------------------------
module sarsa_q_table_update
	import sqtu_pkg::*;
#(
	parameter int GRID_W  = 16,
	parameter int GRID_H  = 8,
	parameter int ACTIONS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        start,
	input  item_t       item,
	output logic        busy,
	output logic        done,
	output result_t     result
);

	ctl_t  ctl;
	stat_t stat;

	sqtu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_cmd (item.cmd),
		.stat      (stat),
		.ctl       (ctl),
		.busy      (busy)
	);

	sqtu_datapath #(
		.GRID_W  (GRID_W),
		.GRID_H  (GRID_H),
		.ACTIONS (ACTIONS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.ctl       (ctl),
		.stat      (stat),
		.done      (done),
		.result    (result)
	);

endmodule

// ===== rtl/core/sqtu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SARSA Q-table update: controller
// Sequences one item: table scan of the next cell, the current entry read,
// two multiply steps with the TD sum between, and the write-back. A load goes straight to write-back.
// ----------------------------------------------------------------------------
module sqtu_ctrl
	import sqtu_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  start_cmd,
	input  stat_t stat,
	output ctl_t  ctl,
	output logic  busy
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCAN  = 7'b0000010,
		ST_DRAIN = 7'b0000100,
		ST_MUL1  = 7'b0001000,
		ST_TD    = 7'b0010000,
		ST_MUL2  = 7'b0100000,
		ST_WB    = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					state_d   = (start_cmd == CMD_STEP) ? ST_SCAN : ST_WB;
				end
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			// last read (current entry) lands in this cycle
			ST_DRAIN: state_d = ST_MUL1;
			ST_MUL1: begin
				ctl.mul1 = 1'b1;
				state_d  = ST_TD;
			end
			ST_TD: begin
				ctl.td  = 1'b1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				ctl.mul2 = 1'b1;
				state_d  = ST_WB;
			end
			ST_WB: begin
				ctl.wb  = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/sqtu_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SARSA Q-table update: datapath
// Q table memory, configuration registers, argmax scan, the two
// fixed-point multiplies with rounding, saturation and the result register.
// ----------------------------------------------------------------------------
module sqtu_datapath
	import sqtu_pkg::*;
#(
	parameter int GRID_W  = 16,
	parameter int GRID_H  = 8,
	parameter int ACTIONS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  item_t       item,
	input  ctl_t        ctl,
	output stat_t       stat,
	output logic        done,
	output result_t     result
);

	localparam int DEPTH = GRID_W * GRID_H * ACTIONS;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = $clog2(ACTIONS + 1);

	function automatic logic [AW-1:0] entry_idx(input int x, input int y, input int a);
		int cx;
		int cy;
		cx = (x >= GRID_W) ? GRID_W - 1 : x;
		cy = (y >= GRID_H) ? GRID_H - 1 : y;
		return AW'((cy * GRID_W + cx) * ACTIONS + a);
	endfunction

	logic signed [15:0] mem [DEPTH];

	logic [15:0]        learn_q, discount_q, explore_q;
	item_t              item_q;
	logic               explore_hit_q;
	logic [KW-1:0]      rnd_k_q;
	logic [KW-1:0]      cnt_q;
	logic               rv_s1;
	logic [KW-1:0]      rk_s1;
	logic signed [15:0] rd_q;
	logic signed [15:0] best_q, rnd_val_q, q_q;
	logic [KW-1:0]      best_k_q;
	logic signed [32:0] prod1_q;
	logic signed [17:0] td_q;
	logic signed [34:0] prod2_q;
	logic               done_q;
	result_t            result_q;

	logic [AW-1:0]      cur_idx, base_idx, rd_addr;
	int                 act_c;
	logic signed [15:0] qnext;
	logic [KW-1:0]      na;
	logic signed [32:0] sum1;
	logic signed [16:0] gq;
	logic signed [17:0] rw;
	logic signed [34:0] sum2;
	logic signed [18:0] delta;
	logic signed [19:0] nq_wide;
	logic signed [15:0] nq;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_q    <= LEARN_RATE_RST;
			discount_q <= DISCOUNT_RST;
			explore_q  <= EXPLORE_RATE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LEARN_RATE:   learn_q    <= cfg_wdata;
				REG_DISCOUNT:     discount_q <= cfg_wdata;
				REG_EXPLORE_RATE: explore_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// addresses
	always_comb begin
		act_c    = (int'(item_q.act) >= ACTIONS) ? ACTIONS - 1 : int'(item_q.act);
		cur_idx  = entry_idx(int'(item_q.cur_x), int'(item_q.cur_y), act_c);
		base_idx = entry_idx(int'(item_q.next_x), int'(item_q.next_y), 0);
		rd_addr  = (cnt_q == KW'(ACTIONS)) ? cur_idx : base_idx + AW'(cnt_q);
	end

	assign stat.scan_last = (cnt_q == KW'(ACTIONS));

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.wb) begin
			mem[cur_idx] <= nq;
		end
		if (ctl.scan) begin
			rd_q <= mem[rd_addr];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (ctl.latch) begin
				cnt_q <= '0;
			end else if (ctl.scan) begin
				cnt_q <= cnt_q + KW'(1);
			end
			rv_s1  <= ctl.scan;
			done_q <= ctl.wb;
		end
	end

	// item capture and scan evaluation
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			item_q        <= item;
			explore_hit_q <= (item.explore_draw < explore_q);
			// the 2-bit action never reaches twice ACTIONS: one subtract wraps it
			rnd_k_q       <= (int'(item.random_action) >= ACTIONS)
				? KW'(int'(item.random_action) - ACTIONS) : KW'(item.random_action);
		end
		rk_s1 <= cnt_q;
		if (rv_s1) begin
			if (rk_s1 == KW'(ACTIONS)) begin
				q_q <= rd_q;
			end else begin
				// strict compare: lowest action wins a tie
				if (rk_s1 == '0 || rd_q > best_q) begin
					best_q   <= rd_q;
					best_k_q <= rk_s1;
				end
				if (rk_s1 == rnd_k_q) begin
					rnd_val_q <= rd_q;
				end
			end
		end
	end

	// arithmetic
	always_comb begin
		qnext   = explore_hit_q ? rnd_val_q : best_q;
		na      = explore_hit_q ? rnd_k_q : best_k_q;
		sum1    = prod1_q + 33'sd32768;
		gq      = sum1[32:16];
		rw      = {{2{item_q.reward[7]}}, item_q.reward, 8'h00};
		sum2    = prod2_q + 35'sd32768;
		delta   = sum2[34:16];
		nq_wide = {{4{q_q[15]}}, q_q} + {delta[18], delta};
		if (item_q.cmd == CMD_LOAD) begin
			nq = item_q.load_value;
		end else if (nq_wide > 20'sd32767) begin
			nq = 16'sh7fff;
		end else if (nq_wide < -20'sd32768) begin
			nq = -16'sh8000;
		end else begin
			nq = nq_wide[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul1) begin
			prod1_q <= $signed({1'b0, discount_q}) * qnext;
		end
		if (ctl.td) begin
			td_q <= rw + {gq[16], gq} - {{2{q_q[15]}}, q_q};
		end
		if (ctl.mul2) begin
			prod2_q <= $signed({1'b0, learn_q}) * td_q;
		end
		if (ctl.wb) begin
			result_q.new_q       <= nq;
			result_q.next_action <= (item_q.cmd == CMD_LOAD) ? 2'd0 : 2'(na);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/core/sqtu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SARSA Q-table update: port checker
// Watches the command and result ports for ordering of busy, done and load
// results.
// ----------------------------------------------------------------------------
module sqtu_checker
	import sqtu_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input item_t   item,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// a result only appears once the engine has finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// one strobe per item
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	// a load is written back in the next cycle and reported the one after
	a_load_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_LOAD) |=> busy ##1 done)
		else $error("load item not reported on time");

	// a load echoes its value with action zero
	a_load_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_LOAD) |=> ##1
			(result.new_q == $past(item.load_value, 2) && result.next_action == 2'd0))
		else $error("load result does not echo the loaded value");

	// a step item keeps the engine busy
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_STEP) |=> (busy && !done) ##1 (busy && !done))
		else $error("step item finished too early");

endmodule

bind sarsa_q_table_update sqtu_checker u_sqtu_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.item   (item),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== bench/tb_sarsa_q_table_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SARSA Q-table update engine testbench
// Drives load and step items through the command port. A shadow Q table
// with its own alpha, gamma and epsilon predicts each result. Each strobed
// result is compared with the oldest prediction. Directed phases cover
// extremes, ties, exploration limits and saturation. A random walk on a
// small patch of the grid then runs under several register settings.
// ----------------------------------------------------------------------------
module tb_sarsa_q_table_update;
	import sqtu_pkg::*;

	localparam int GRID_W      = 16;
	localparam int GRID_H      = 8;
	localparam int ACTIONS     = 4;
	localparam int ENTRIES     = GRID_W * GRID_H * ACTIONS;
	localparam int IDLE_LIMIT  = 5000;
	localparam int MAX_REPORTS = 10;
	localparam int CHUNK_ITEMS = 100;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;
	logic        start;
	item_t       item;
	logic        busy;
	logic        done;
	result_t     result;

	sarsa_q_table_update #(
		.GRID_W (GRID_W),
		.GRID_H (GRID_H),
		.ACTIONS(ACTIONS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start    (start),
		.item     (item),
		.busy     (busy),
		.done     (done),
		.result   (result)
	);

	always #5 clk = ~clk;

	// shadow copy of the block
	logic signed [15:0] q_shadow [ENTRIES];
	bit                 written  [ENTRIES];
	logic [15:0]        alpha_q16;
	logic [15:0]        gamma_q16;
	logic [15:0]        eps_q16;

	result_t pending_results [$];
	int      mismatches;
	int      burst_left;
	int      items_sent;
	int      idle_cycles;

	function automatic int unsigned clamp_coord(int unsigned v, int unsigned lim);
		return (v >= lim) ? lim - 1 : v;
	endfunction

	function automatic int unsigned entry_of(int unsigned x, int unsigned y, int unsigned a);
		return ((clamp_coord(y, GRID_H) * GRID_W) + clamp_coord(x, GRID_W)) * ACTIONS
			+ clamp_coord(a, ACTIONS);
	endfunction

	// round to nearest, halves toward +infinity
	function automatic longint round_q16(longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	// apply one item to the shadow table and return the result it causes
	function automatic result_t q_update(item_t it);
		result_t     res;
		int unsigned cur;
		int unsigned base;
		int unsigned na;
		logic signed [15:0] best;
		longint      qn;
		longint      qc;
		longint      gq;
		longint      td;
		longint      nq;
		cur = entry_of(it.cur_x, it.cur_y, it.act);
		if (it.cmd == CMD_LOAD) begin
			q_shadow[cur] = it.load_value;
			written[cur]  = 1'b1;
			res.next_action = '0;
			res.new_q       = it.load_value;
			return res;
		end
		base = entry_of(it.next_x, it.next_y, 0);
		if (it.explore_draw < eps_q16) begin
			na = it.random_action % ACTIONS;
		end else begin
			na   = 0;
			best = q_shadow[base];
			for (int k = 1; k < ACTIONS; k++) begin
				if (q_shadow[base + k] > best) begin
					best = q_shadow[base + k];
					na   = k;
				end
			end
		end
		qn = longint'(q_shadow[base + na]);
		qc = longint'(q_shadow[cur]);
		gq = round_q16(longint'(gamma_q16) * qn);
		td = longint'(it.reward) * 256 + gq - qc;
		nq = qc + round_q16(longint'(alpha_q16) * td);
		if (nq > 32767)
			nq = 32767;
		if (nq < -32768)
			nq = -32768;
		q_shadow[cur]   = nq[15:0];
		res.next_action = na[1:0];
		res.new_q       = nq[15:0];
		return res;
	endfunction

	function automatic item_t random_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(item_t)-1:0];
	endfunction

	function automatic logic signed [15:0] random_q();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 8191) - 4096);
		endcase
	endfunction

	function automatic item_t make_load(logic [3:0] x, logic [2:0] y, logic [1:0] a,
		logic signed [15:0] v);
		item_t it;
		it            = random_item();
		it.cmd        = CMD_LOAD;
		it.cur_x      = x;
		it.cur_y      = y;
		it.act        = a;
		it.load_value = v;
		return it;
	endfunction

	function automatic item_t make_step(logic [3:0] cx, logic [2:0] cy, logic [1:0] a,
		logic signed [7:0] r, logic [3:0] nx, logic [2:0] ny, logic [15:0] draw,
		logic [1:0] ra);
		item_t it;
		it               = random_item();
		it.cmd           = CMD_STEP;
		it.cur_x         = cx;
		it.cur_y         = cy;
		it.act           = a;
		it.reward        = r;
		it.next_x        = nx;
		it.next_y        = ny;
		it.explore_draw  = draw;
		it.random_action = ra;
		return it;
	endfunction

	// send one item in bursts with random gaps; start stays high inside a burst
	task automatic send_item(item_t it);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		pending_results.push_back(q_update(it));
		items_sent++;
	endtask

	task automatic ensure_loaded(logic [3:0] x, logic [2:0] y, logic [1:0] a);
		if (!written[entry_of(x, y, a)])
			send_item(make_load(x, y, a, random_q()));
	endtask

	// load whatever a step would read before it goes in
	task automatic send_step(item_t it);
		ensure_loaded(it.cur_x, it.cur_y, it.act);
		for (int k = 0; k < ACTIONS; k++)
			ensure_loaded(it.next_x, it.next_y, k[1:0]);
		send_item(it);
	endtask

	// drop start and wait for the block to go idle
	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_regs(logic [15:0] lr, logic [15:0] dc, logic [15:0] er);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_LEARN_RATE;
		cfg_wdata <= lr;
		@(posedge clk);
		cfg_index <= REG_DISCOUNT;
		cfg_wdata <= dc;
		@(posedge clk);
		cfg_index <= REG_EXPLORE_RATE;
		cfg_wdata <= er;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		alpha_q16 = lr;
		gamma_q16 = dc;
		eps_q16   = er;
	endtask

	task automatic test_load_extremes();
		send_item(make_load(4'd0, 3'd0, 2'd0, 16'sh7FFF));
		send_item(make_load(4'd0, 3'd0, 2'd1, 16'sh8000));
		send_item(make_load(4'd0, 3'd0, 2'd2, 16'sh0000));
		send_item(make_load(4'd0, 3'd0, 2'd3, 16'sh0001));
		send_item(make_load(4'd15, 3'd7, 2'd3, 16'shFFFF));
		send_item(make_load(4'd15, 3'd7, 2'd0, 16'sh0100));
		send_item(make_load(4'd15, 3'd7, 2'd1, -16'sh0100));
		send_item(make_load(4'd15, 3'd7, 2'd2, 16'sh5555));
	endtask

	task automatic test_greedy_and_ties();
		for (int k = 0; k < ACTIONS; k++)
			send_item(make_load(4'd1, 3'd0, k[1:0], 16'sh0280));
		send_step(make_step(4'd15, 3'd7, 2'd3, 8'sd127, 4'd0, 3'd0, 16'hFFFF, 2'd0));
		// all-equal next cell: lowest action wins
		send_step(make_step(4'd15, 3'd7, 2'd0, -8'sd128, 4'd1, 3'd0, 16'hFFFF, 2'd2));
		send_step(make_step(4'd15, 3'd7, 2'd1, 8'sd5, 4'd1, 3'd0, 16'h0000, 2'd3));
	endtask

	task automatic test_saturation();
		write_regs(16'hFFFF, 16'hFFFF, 16'h0000);
		send_step(make_step(4'd0, 3'd0, 2'd0, 8'sd127, 4'd0, 3'd0, 16'h0000, 2'd1));
		for (int k = 0; k < ACTIONS; k++)
			send_item(make_load(4'd2, 3'd0, k[1:0], 16'sh8000));
		send_step(make_step(4'd0, 3'd0, 2'd1, -8'sd128, 4'd2, 3'd0, 16'h1234, 2'd3));
	endtask

	task automatic test_epsilon_extremes();
		write_regs(LEARN_RATE_RST, DISCOUNT_RST, 16'hFFFF);
		send_step(make_step(4'd15, 3'd7, 2'd2, 8'sd3, 4'd0, 3'd0, 16'hFFFE, 2'd2));
		send_step(make_step(4'd15, 3'd7, 2'd2, -8'sd3, 4'd0, 3'd0, 16'hFFFF, 2'd1));
	endtask

	task automatic test_zero_rates();
		write_regs(16'h0000, 16'h0000, 16'h0000);
		send_step(make_step(4'd15, 3'd7, 2'd0, 8'sd100, 4'd0, 3'd0, 16'h0000, 2'd0));
		write_regs(16'hFFFF, 16'h0000, 16'h8000);
		send_step(make_step(4'd15, 3'd7, 2'd1, -8'sd77, 4'd1, 3'd0, 16'h7FFF, 2'd2));
	endtask

	// mostly steps on a small patch so values evolve; some loads and far steps
	task automatic test_random_walk();
		item_t it;
		int    target;
		for (int chunk = 0; chunk < 4; chunk++) begin
			case (chunk)
				0: write_regs(16'($urandom), 16'($urandom), 16'($urandom));
				1: write_regs(16'hFFFF, 16'hFFFF, 16'($urandom));
				2: write_regs(16'($urandom_range(0, 4095)), 16'($urandom), 16'h0000);
				default: write_regs(16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			target = items_sent + CHUNK_ITEMS;
			while (items_sent < target) begin
				it = random_item();
				case ($urandom_range(0, 19))
					0, 1: begin
						it.cmd        = CMD_LOAD;
						it.load_value = random_q();
						send_item(it);
					end
					2, 3, 4: begin
						it.cmd = CMD_STEP;
						send_step(it);
					end
					default: begin
						it.cmd    = CMD_STEP;
						it.cur_x  = 4'($urandom_range(0, 3));
						it.cur_y  = 3'($urandom_range(0, 1));
						it.next_x = 4'($urandom_range(0, 3));
						it.next_y = 3'($urandom_range(0, 1));
						if ($urandom_range(0, 1))
							it.reward = 8'($urandom_range(0, 8) - 4);
						send_step(it);
					end
				endcase
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: next_action=%0d new_q=%0d",
						result.next_action, result.new_q);
			end else begin
				want = pending_results.pop_front();
				if (result.next_action !== want.next_action
					|| result.new_q !== want.new_q) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"mismatch: expected next_action=%0d new_q=%0d, ",
							"got next_action=%0d new_q=%0d"},
							want.next_action, want.new_q, result.next_action,
							result.new_q);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		cfg_wr_en   = 1'b0;
		cfg_index   = REG_LEARN_RATE;
		cfg_wdata   = '0;
		alpha_q16   = LEARN_RATE_RST;
		gamma_q16   = DISCOUNT_RST;
		eps_q16     = EXPLORE_RATE_RST;
		mismatches  = 0;
		burst_left  = 0;
		items_sent  = 0;
		idle_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_extremes();
		test_greedy_and_ties();
		test_saturation();
		test_epsilon_extremes();
		test_zero_rates();
		test_random_walk();
		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
